[design/adsr_pkg.sv]
// Shared types and constants for the ADSR envelope generator.
package adsr_pkg;

  localparam int UNDERSAMPLE_LOG2 = 5;
  localparam int TICK_W           = (UNDERSAMPLE_LOG2 > 0) ? UNDERSAMPLE_LOG2 : 1;
  localparam int SAMPLE_RATE_HZ   = 48000;
  localparam int MS_PER_S         = 1000;
  localparam int MS_SCALE         = SAMPLE_RATE_HZ / MS_PER_S;
  localparam int LEVEL_SHIFT      = 17;
  localparam int DIVS_W           = 22;  // 16-bit ms times 48
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUSTAIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GATE    = 3'd4;

  localparam logic [1:0] MODE_START = 2'd1;
  localparam logic [1:0] MODE_STOP  = 2'd2;

  typedef enum logic [1:0] {
    EVT_NONE,
    EVT_START,
    EVT_STOP
  } evt_t;

  typedef enum logic [2:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  // envelope engine sequencer
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVENT,
    ST_REL_WAIT,
    ST_ADV,
    ST_ADV_WAIT,
    ST_MUL,
    ST_EMIT
  } bst_t;

  // classified input word as it sits in the queue
  typedef struct packed {
    evt_t               evt;
    logic               tick;    // counter steps on this sample
    logic signed [15:0] sample;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [31:0]       dividend;
    logic [DIVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
  } div_rsp_t;

endpackage

[design/adsr_front.sv]
// Input side: accepts sample words, decodes the event and tracks the step tick.
module adsr_front import adsr_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        q_full,
  output logic        q_push,
  output item_t       q_item
);

  localparam logic [TICK_W-1:0] TICK_MASK = TICK_W'((1 << UNDERSAMPLE_LOG2) - 1);

  logic [TICK_W-1:0] tick_count;
  evt_t              evt;

  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    unique case (s_tuser)
      MODE_START: evt = EVT_START;
      MODE_STOP:  evt = EVT_STOP;
      default:    evt = EVT_NONE;   // none, and the unused code
    endcase
  end

  assign q_item.evt    = evt;
  assign q_item.tick   = ((tick_count & TICK_MASK) == '0);
  assign q_item.sample = s_tdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (q_push) begin
      tick_count <= (tick_count + 1'b1) & TICK_MASK;
    end
  end

endmodule

[design/adsr_queue.sv]
// Four-entry queue between the input side and the envelope engine.
module adsr_queue import adsr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  item_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full  = (count == (PTR_W+1)'(DEPTH));
  assign valid = (count != '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

endmodule

[design/adsr_div.sv]
// Restoring divider, one quotient bit per cycle.
module adsr_div import adsr_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy;
  logic              done;
  logic [4:0]        cnt;
  logic [DIVS_W-1:0] rem;
  logic [DIVS_W-1:0] dvs;
  logic [31:0]       quo;
  logic [DIVS_W:0]   trial;
  logic [DIVS_W:0]   diff;

  assign trial = {rem, quo[31]};
  assign diff  = trial - {1'b0, dvs};

  assign rsp.done     = done;
  assign rsp.quotient = quo;

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      if (!diff[DIVS_W]) begin
        rem <= diff[DIVS_W-1:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial[DIVS_W-1:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[design/adsr_back.sv]
// Envelope engine: event handling, counter step, gain multiply, output register.
module adsr_back import adsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  item_t                 q_head,
  output logic                  q_pop,
  output div_req_t              div_req,
  input  div_rsp_t              div_rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata
);

  bst_t state, state_next;

  logic [15:0] attack_ms, decay_ms, release_ms;
  logic [14:0] sustain_lvl, gate_lvl;

  item_t                 item;
  phase_t                phase;
  logic [31:0]           level;
  logic [31:0]           release_step;
  logic [14:0]           held;
  logic signed [31:0]    prod;
  logic signed [15:0]    out_audio;
  phase_t                out_phase;

  logic        rel_start, adv_start, apply_step, out_free;
  logic [31:0] sus, gate, step_val, lvl_step;
  logic [32:0] sum;
  logic [31:0] dec_t;
  phase_t      ph_step;

  function automatic logic [31:0] scale_step(input logic [31:0] v);
    if (UNDERSAMPLE_LOG2 == 0) return v;
    if ((v >> (32 - UNDERSAMPLE_LOG2)) != '0) return '1;
    return v << UNDERSAMPLE_LOG2;
  endfunction

  function automatic logic [DIVS_W-1:0] ms_divisor(input logic [15:0] ms);
    return DIVS_W'({{(DIVS_W-16){1'b0}}, ms} * DIVS_W'(MS_SCALE));
  endfunction

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign sus       = {sustain_lvl, 17'b0};
  assign gate      = {gate_lvl, 17'b0};

  assign rel_start = (item.evt == EVT_STOP) && (phase != PH_OFF) && (release_ms != '0);
  assign adv_start = item.tick &&
                     (((phase == PH_ATTACK) && (attack_ms != '0)) ||
                      ((phase == PH_DECAY) && (decay_ms != '0)));
  assign apply_step = ((state == ST_ADV) && item.tick && !adv_start) ||
                      ((state == ST_ADV_WAIT) && div_rsp.done);

  // zero time gives the saturated step
  assign step_val = (state == ST_ADV_WAIT) ? scale_step(div_rsp.quotient) : '1;
  assign sum      = {1'b0, level} + {1'b0, step_val};
  assign dec_t    = (step_val > level) ? '0 : (level - step_val);

  always_comb begin
    lvl_step = level;
    ph_step  = phase;
    unique case (phase)
      PH_ATTACK: begin
        if (sum[32]) begin
          lvl_step = '1;
          ph_step  = PH_DECAY;
        end else begin
          lvl_step = sum[31:0];
        end
      end
      PH_DECAY: begin
        if (dec_t <= sus) begin
          lvl_step = sus;
          ph_step  = PH_SUSTAIN;
        end else if (dec_t < gate) begin
          lvl_step = '0;
          ph_step  = PH_OFF;
        end else begin
          lvl_step = dec_t;
        end
      end
      PH_SUSTAIN: begin
        lvl_step = sus;
        if (sus == '0) ph_step = PH_OFF;
      end
      PH_RELEASE: begin
        if (release_step > level) begin
          lvl_step = '0;
          ph_step  = PH_OFF;
        end else begin
          lvl_step = level - release_step;
        end
      end
      default: begin
        lvl_step = '0;
        ph_step  = PH_OFF;
      end
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (q_valid) state_next = ST_EVENT;
      ST_EVENT:    state_next = rel_start ? ST_REL_WAIT : ST_ADV;
      ST_REL_WAIT: if (div_rsp.done) state_next = ST_ADV;
      ST_ADV:      state_next = adv_start ? ST_ADV_WAIT : ST_MUL;
      ST_ADV_WAIT: if (div_rsp.done) state_next = ST_MUL;
      ST_MUL:      state_next = ST_EMIT;
      ST_EMIT:     if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // outputs to queue and divider
  always_comb begin
    q_pop            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = level;
    div_req.divisor  = ms_divisor(release_ms);
    unique case (state)
      ST_IDLE:  q_pop = q_valid;
      ST_EVENT: div_req.start = rel_start;
      ST_ADV: begin
        div_req.start    = adv_start;
        div_req.dividend = (phase == PH_DECAY) ? ~sus : '1;
        div_req.divisor  = ms_divisor((phase == PH_DECAY) ? decay_ms : attack_ms);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ms   <= 16'd100;
      decay_ms    <= 16'd250;
      sustain_lvl <= 15'd16000;
      release_ms  <= 16'd50;
      gate_lvl    <= 15'd0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_ATTACK:  attack_ms   <= cfg_data;
        CFG_DECAY:   decay_ms    <= cfg_data;
        CFG_SUSTAIN: sustain_lvl <= cfg_data[14:0];
        CFG_RELEASE: release_ms  <= cfg_data;
        CFG_GATE:    gate_lvl    <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_OFF;
      level        <= '0;
      release_step <= '0;
      held         <= '0;
    end else begin
      if (state == ST_EVENT) begin
        if ((item.evt == EVT_STOP) && (phase != PH_OFF)) begin
          phase <= PH_RELEASE;
          if (release_ms == '0) release_step <= '1;
        end else if (item.evt == EVT_START) begin
          phase <= PH_ATTACK;
        end
      end
      if ((state == ST_REL_WAIT) && div_rsp.done) begin
        release_step <= scale_step(div_rsp.quotient);
      end
      if (apply_step) begin
        level <= lvl_step;
        phase <= ph_step;
        held  <= lvl_step[31:LEVEL_SHIFT];
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && q_valid) item <= q_head;
    if (state == ST_MUL) prod <= 32'(item.sample) * $signed({17'b0, held});
    if ((state == ST_EMIT) && out_free) begin
      out_audio <= prod[30:15];
      out_phase <= phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == ST_EMIT) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  assign m_tdata = {5'b0, out_phase, out_audio};

endmodule

[design/adsr_envelope_generator.sv]
// Each word is popped in idle, then passes the event, advance, multiply and emit states,
// waiting on the divider for each divide; an item needs at most one (release step at
// note stop, or attack/decay step). One item at a time, held up by the bit-serial 32-bit
// divider and output stalls; a 4-word queue keeps input acceptance going meanwhile.
// Reset (synchronous, rst high): phase off, counter, release step and tick cleared,
// registers to defaults; the block is ready as soon as reset is released.
module adsr_envelope_generator import adsr_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // [15:0] audio_in
  input  logic [1:0]            s_tuser,   // [1:0] mode
  // output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [23:0]           m_tdata,   // [15:0] audio_out, [18:16] phase, zero pad
  // register writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  item_t    q_item, q_head;
  logic     q_push, q_pop, q_full, q_valid;
  div_req_t div_req;
  div_rsp_t div_rsp;

  // front: decode event, stamp tick, push word
  adsr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_item)
  );

  adsr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // shared step divider
  adsr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // back: envelope state machine and output register
  adsr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .div_req   (div_req),
    .div_rsp   (div_rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

[design/adsr_checker.sv]
// Port-level assertions for the envelope generator, bound to the top level.
module adsr_checker import adsr_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [23:0]           m_tdata
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[18:16] <= PH_RELEASE))
    else $error("phase code out of range");

  a_off_silent: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[18:16] == PH_OFF) |-> (m_tdata[15:0] == 16'd0))
    else $error("nonzero audio while envelope off");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[23:19] == 5'd0))
    else $error("output pad bits set");

endmodule

bind adsr_envelope_generator adsr_checker u_chk (.*);

[verif/testbench.sv]
// Self-checking testbench for the ADSR envelope generator: directed table, then random notes.
module testbench;
  import adsr_pkg::*;

  localparam logic [1:0] MODE_IDLE = 2'd0;  // no event with this sample
  localparam logic [1:0] MODE_RSVD = 2'd3;  // unused code, acts as no event
  localparam int NUM_ROWS = 16;
  localparam int NUM_SETTINGS = 6;
  localparam int WORDS_PER_SETTING = 75;
  localparam int DRAIN_CYCLES = 50;  // about one divide plus pipeline
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [15:0] audio;
    phase_t      phase;
  } env_word_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] audio;
    logic        typed;  // expectation typed in below, else from the predictor
    env_word_t   want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [15:0]           s_tdata = '0;
  logic [1:0]            s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [23:0]           m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  adsr_envelope_generator u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor copy of the block state and registers
  phase_t              env_ph;
  logic [31:0]         env_level;
  logic [31:0]         env_rel_step;
  logic [TICK_W-1:0]   env_tick;
  logic [14:0]         env_held;
  logic [15:0]         set_attack_ms, set_decay_ms, set_release_ms;
  logic [14:0]         set_sustain, set_gate;

  env_word_t expected_words[$];
  env_word_t seen_exp;
  int        errors = 0;
  int        random_words = 0;
  int        rx_hold = 0;
  bit        rx_calm = 1'b0;
  bit        tx_calm = 1'b0;
  logic [15:0] reg_plan [5];
  stim_row_t   directed_rows [NUM_ROWS];

  // given span over ms*48 samples, times the undersampling, saturated
  function automatic logic [31:0] env_step_size(input logic [15:0] ms, input logic [31:0] span);
    logic [31:0] q;
    if (ms == '0) q = 32'hFFFF_FFFF;
    else q = span / (32'(ms) * MS_SCALE);
    if (UNDERSAMPLE_LOG2 == 0) return q;
    if ((q >> (32 - UNDERSAMPLE_LOG2)) != '0) return 32'hFFFF_FFFF;
    return q << UNDERSAMPLE_LOG2;
  endfunction

  // event first, then the envelope step on tick zero, then the scaled sample
  function automatic env_word_t predict_envelope_word(input logic [1:0] mode,
                                                      input logic [15:0] audio);
    logic [31:0] sus, gate, st, t;
    logic signed [31:0] prod;
    env_word_t w;
    sus = {set_sustain, {LEVEL_SHIFT{1'b0}}};
    gate = {set_gate, {LEVEL_SHIFT{1'b0}}};
    if (mode == MODE_STOP) begin
      if (env_ph != PH_OFF) begin
        env_ph = PH_RELEASE;
        env_rel_step = env_step_size(set_release_ms, env_level);
      end
    end else if (mode == MODE_START) begin
      env_ph = PH_ATTACK;
    end
    if (env_tick == '0) begin
      case (env_ph)
        PH_ATTACK: begin
          st = env_step_size(set_attack_ms, 32'hFFFF_FFFF);
          t = env_level + st;
          if (t < env_level) begin
            t = 32'hFFFF_FFFF;
            env_ph = PH_DECAY;
          end
          env_level = t;
        end
        PH_DECAY: begin
          st = env_step_size(set_decay_ms, 32'hFFFF_FFFF - sus);
          t = env_level - st;
          if (t > env_level) t = '0;
          env_level = t;
          if (env_level <= sus) begin
            env_level = sus;
            env_ph = PH_SUSTAIN;
          end else if (env_level < gate) begin
            env_level = '0;
            env_ph = PH_OFF;
          end
        end
        PH_SUSTAIN: begin
          if (sus == '0) env_ph = PH_OFF;
          env_level = sus;
        end
        PH_RELEASE: begin
          t = env_level - env_rel_step;
          if (t > env_level) begin
            t = '0;
            env_ph = PH_OFF;
          end
          env_level = t;
        end
        default: begin
          env_ph = PH_OFF;
          env_level = '0;
        end
      endcase
      env_held = env_level[31:LEVEL_SHIFT];
    end
    env_tick = env_tick + 1'b1;
    prod = $signed(audio) * $signed({1'b0, env_held});
    w.audio = prod[30:15];
    w.phase = env_ph;
    return w;
  endfunction

  // one input word: random gap (or a full drain now and then), then handshake
  task automatic send_word(input logic [1:0] mode, input logic [15:0] audio,
                           input logic typed, input env_word_t want);
    int gap;
    env_word_t got;
    if ($urandom_range(0, 23) == 0) tx_calm = !tx_calm;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if ($urandom_range(0, 99) == 0) begin
      s_tvalid <= 1'b0;
      wait_drained();
    end else if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= audio;
    s_tuser <= mode;
    do @(posedge clk); while (!s_tready);
    got = predict_envelope_word(mode, audio);
    expected_words.push_back(typed ? want : got);
  endtask

  task automatic send_random(input logic [1:0] mode);
    logic [1:0] m;
    m = mode;
    if ($urandom_range(0, 11) == 0) m = 2'($urandom_range(0, 3));  // noise
    send_word(m, 16'($urandom), 1'b0, '0);
    random_words++;
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (expected_words.size() != 0);
  endtask

  // writes the selected registers from reg_plan, block idle
  task automatic program_regs(input logic [4:0] sel);
    for (int i = 0; i < 5; i++) begin
      if (sel[i]) begin
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(i);
        cfg_data <= reg_plan[i];
        do @(posedge clk); while (!cfg_ready);
        case (CFG_IDX_W'(i))
          CFG_ATTACK:  set_attack_ms = reg_plan[i];
          CFG_DECAY:   set_decay_ms = reg_plan[i];
          CFG_SUSTAIN: set_sustain = reg_plan[i][14:0];
          CFG_RELEASE: set_release_ms = reg_plan[i];
          CFG_GATE:    set_gate = reg_plan[i][14:0];
          default: ;
        endcase
      end
    end
    cfg_valid <= 1'b0;
  endtask

  // mostly 1 to 3 ms, so each timed phase runs roughly 48 to 144 samples
  function automatic logic [15:0] pick_time();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 3));
    endcase
  endfunction

  function automatic logic [15:0] pick_level();
    case ($urandom_range(0, 5))
      0: return 16'd0;
      1: return 16'h7FFF;
      default: return 16'($urandom_range(0, 32767));
    endcase
  endfunction

  // note on, held, note off, tail
  task automatic play_note();
    int hold_len, tail_len;
    hold_len = $urandom_range(2, 90);
    tail_len = $urandom_range(2, 60);
    send_random(MODE_START);
    repeat (hold_len) send_random(MODE_IDLE);
    send_random(MODE_STOP);
    repeat (tail_len) send_random(MODE_IDLE);
  endtask

  // output side: random stalls per word, checked against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      rx_hold = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected word %h", m_tdata);
        end else begin
          seen_exp = expected_words.pop_front();
          if (m_tdata[15:0] !== seen_exp.audio || m_tdata[18:16] !== seen_exp.phase ||
              m_tdata[23:19] !== '0) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display("mismatch: expected audio %h phase %0d, got audio %h phase %0d pad %h",
                       seen_exp.audio, seen_exp.phase, m_tdata[15:0], m_tdata[18:16],
                       m_tdata[23:19]);
          end
        end
        if ($urandom_range(0, 19) == 0) rx_calm = !rx_calm;
        rx_hold = rx_calm ? 0 : $urandom_range(0, 6);
      end
      if (rx_hold > 0) begin
        m_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    env_ph = PH_OFF;
    env_level = '0;
    env_rel_step = '0;
    env_tick = '0;
    env_held = '0;
    set_attack_ms = 16'd100;
    set_decay_ms = 16'd250;
    set_sustain = 15'd16000;
    set_release_ms = 16'd50;
    set_gate = 15'd0;

    // the only envelope step here, on the first row, finds the block off,
    // so the level stays zero
    directed_rows = '{
      '{MODE_IDLE,  16'h7FFF, 1'b1, '{16'h0000, PH_OFF}},
      '{MODE_IDLE,  16'h8000, 1'b1, '{16'h0000, PH_OFF}},
      '{MODE_RSVD,  16'hFFFF, 1'b1, '{16'h0000, PH_OFF}},
      '{MODE_STOP,  16'h0001, 1'b1, '{16'h0000, PH_OFF}},     // note off while off
      '{MODE_START, 16'h8000, 1'b1, '{16'h0000, PH_ATTACK}},
      '{MODE_IDLE,  16'h7FFF, 1'b1, '{16'h0000, PH_ATTACK}},
      '{MODE_STOP,  16'hFFFF, 1'b1, '{16'h0000, PH_RELEASE}},
      '{MODE_STOP,  16'h0000, 1'b1, '{16'h0000, PH_RELEASE}}, // note off in release
      '{MODE_START, 16'h7FFF, 1'b1, '{16'h0000, PH_ATTACK}},
      '{MODE_RSVD,  16'h8001, 1'b0, '0},
      '{MODE_START, 16'h4000, 1'b0, '0},                      // retrigger in attack
      '{MODE_STOP,  16'hC000, 1'b0, '0},
      '{MODE_RSVD,  16'h7FFE, 1'b0, '0},
      '{MODE_START, 16'h0000, 1'b0, '0},                      // retrigger in release
      '{MODE_IDLE,  16'h8000, 1'b0, '0},
      '{MODE_STOP,  16'h7FFF, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < NUM_ROWS; r++)
      send_word(directed_rows[r].mode, directed_rows[r].audio, directed_rows[r].typed,
                directed_rows[r].want);

    // each setting: drain, settle, reprogram, then notes with random content
    for (int k = 0; k < NUM_SETTINGS; k++) begin
      s_tvalid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clk);
      case (k)
        0: begin
          reg_plan[CFG_ATTACK] = 16'd0;
          reg_plan[CFG_DECAY] = 16'd0;
          reg_plan[CFG_SUSTAIN] = 16'h7FFF;
          reg_plan[CFG_RELEASE] = 16'd0;
          reg_plan[CFG_GATE] = 16'h7FFF;
          program_regs(5'b11111);
        end
        1: begin
          reg_plan[CFG_ATTACK] = 16'hFFFF;
          reg_plan[CFG_DECAY] = 16'hFFFF;
          reg_plan[CFG_SUSTAIN] = 16'd0;
          reg_plan[CFG_RELEASE] = 16'hFFFF;
          reg_plan[CFG_GATE] = 16'd0;
          program_regs(5'b11111);
        end
        default: begin
          reg_plan[CFG_ATTACK] = pick_time();
          reg_plan[CFG_DECAY] = pick_time();
          reg_plan[CFG_SUSTAIN] = pick_level();
          reg_plan[CFG_RELEASE] = pick_time();
          reg_plan[CFG_GATE] = pick_level();
          program_regs((k == 2) ? 5'b11111 : 5'($urandom_range(1, 31)));
        end
      endcase
      while (random_words < (k + 1) * WORDS_PER_SETTING) play_note();
    end

    s_tvalid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) errors++;
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
